/* hw/rtl/crs_pkg.sv */
// Package for the chunk reassembly scoreboard: shared types, codes and defaults.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

  localparam int MAX_CHUNKS_DEF      = 64;
  localparam int BYTE_COUNT_BITS_DEF = 32;

  // Field widths fixed by the interface
  localparam int OP_W    = 2;
  localparam int SEQ_W   = 8;
  localparam int LEN_W   = 16;
  localparam int TOTB_W  = 32;
  localparam int CNT_W   = 7;
  localparam int BYTES_W = 32;
  localparam int MASK_W  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED         = 3'd0,
    ST_DUPLICATE        = 3'd1,
    ST_ALREADY_COMPLETE = 3'd2,
    ST_BEYOND_EXPECTED  = 3'd3,
    ST_BEYOND_CAPACITY  = 3'd4,
    ST_TOTALS_SET       = 3'd5,
    ST_EXTENT_EXCEEDS   = 3'd6,
    ST_CLEARED          = 3'd7
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SEQ_W-1:0]  seqno;
    logic [LEN_W-1:0]  chunk_len;
    logic [TOTB_W-1:0] total_bytes;
    logic [CNT_W-1:0]  total_chunks;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               done_res;
    logic [CNT_W-1:0]   chunks_seen;
    logic [BYTES_W-1:0] bytes_seen;
    logic [CNT_W-1:0]   chunk_extent;
    logic [MASK_W-1:0]  missing_mask;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/crs_in_reg.sv */
// Input register stage of the chunk reassembly scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module crs_in_reg
  import crs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t item_in,
  input  wire logic  down_ready,
  output logic       stage_valid,
  output logic       stage_fire,
  output item_t      item
);

  assign stage_fire = stage_valid && down_ready;
  assign in_ready   = !stage_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/crs_core.sv */
// Scoreboard state and the single-pass update and result logic.
`timescale 1ns / 1ps
`default_nettype none

module crs_core
  import crs_pkg::*;
#(
  parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF,
  parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    res
);

  localparam int CMP_W = (BYTE_COUNT_BITS > TOTB_W) ? BYTE_COUNT_BITS : TOTB_W;
  localparam logic [SEQ_W-1:0] SEQ_CAP = SEQ_W'(MAX_CHUNKS);

  logic [MAX_CHUNKS-1:0]      received_map, received_map_next;
  logic [CNT_W-1:0]           extent_count, extent_count_next;
  logic [CNT_W-1:0]           chunk_count, chunk_count_next;
  logic [BYTE_COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [TOTB_W-1:0]          exp_bytes, exp_bytes_next;
  logic [CNT_W-1:0]           exp_chunks, exp_chunks_next;
  logic                       totals_known, totals_known_next;
  logic                       finished, finished_next;

  logic [MAX_CHUNKS-1:0]      seq_hit;
  logic                       dup;
  logic                       complete_now;
  logic [BYTE_COUNT_BITS:0]   byte_sum;
  logic [CNT_W-1:0]           seq_end;
  logic [CNT_W-1:0]           limit;
  logic [MAX_CHUNKS-1:0]      missing;
  logic [CMP_W-1:0]           bytes_wide;
  status_t                    status;

  function automatic logic complete_f(
    input logic [MAX_CHUNKS-1:0]      map,
    input logic [CNT_W-1:0]           ext,
    input logic [CNT_W-1:0]           cnt,
    input logic [BYTE_COUNT_BITS-1:0] bc,
    input logic [TOTB_W-1:0]          eb,
    input logic [CNT_W-1:0]           ec,
    input logic                       tk,
    input logic                       fin
  );
    logic gap;
    gap = 1'b0;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      if (!map[i] && (CNT_W'(i) < ext)) gap = 1'b1;
    end
    return tk && fin && (CMP_W'(bc) == CMP_W'(eb)) && (cnt == ec) && !gap;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      seq_hit[i] = (item.seqno == SEQ_W'(i));
    end
  end

  assign dup          = |(received_map & seq_hit);
  assign complete_now = complete_f(received_map, extent_count, chunk_count, byte_count,
                                   exp_bytes, exp_chunks, totals_known, finished);
  assign byte_sum     = {1'b0, byte_count} + (BYTE_COUNT_BITS + 1)'(item.chunk_len);
  assign seq_end      = CNT_W'(item.seqno) + CNT_W'(1);

  always_comb begin
    received_map_next = received_map;
    extent_count_next = extent_count;
    chunk_count_next  = chunk_count;
    byte_count_next   = byte_count;
    exp_bytes_next    = exp_bytes;
    exp_chunks_next   = exp_chunks;
    totals_known_next = totals_known;
    finished_next     = finished;
    status            = ST_ACCEPTED;
    unique case (item.opcode)
      OP_CLEAR: begin
        received_map_next = '0;
        extent_count_next = '0;
        chunk_count_next  = '0;
        byte_count_next   = '0;
        exp_bytes_next    = '0;
        exp_chunks_next   = '0;
        totals_known_next = 1'b0;
        finished_next     = 1'b0;
        status            = ST_CLEARED;
      end
      OP_ADD: begin
        priority if (complete_now) begin
          status = ST_ALREADY_COMPLETE;
        end else if (totals_known && (item.seqno >= SEQ_W'(exp_chunks))) begin
          status = ST_BEYOND_EXPECTED;
        end else if (item.seqno >= SEQ_CAP) begin
          status = ST_BEYOND_CAPACITY;
        end else if (dup) begin
          status = ST_DUPLICATE;
        end else begin
          received_map_next = received_map | seq_hit;
          chunk_count_next  = chunk_count + CNT_W'(1);
          // saturate at all ones
          byte_count_next   = byte_sum[BYTE_COUNT_BITS] ? '1
                                                        : byte_sum[BYTE_COUNT_BITS-1:0];
          if (seq_end > extent_count) extent_count_next = seq_end;
        end
      end
      OP_FINISH: begin
        if (complete_now) begin
          status = ST_ALREADY_COMPLETE;
        end else begin
          finished_next = 1'b1;
          if (totals_known) begin
            status = ST_TOTALS_SET;
          end else begin
            exp_bytes_next    = item.total_bytes;
            exp_chunks_next   = item.total_chunks;
            totals_known_next = 1'b1;
            status = (extent_count > item.total_chunks) ? ST_EXTENT_EXCEEDS : ST_ACCEPTED;
          end
        end
      end
      default: begin
        status = ST_ACCEPTED;
      end
    endcase
  end

  always_comb begin
    limit = extent_count_next;
    if (totals_known_next && (exp_chunks_next > limit)) limit = exp_chunks_next;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      missing[i] = !received_map_next[i] && (CNT_W'(i) < limit);
    end
  end

  assign bytes_wide = CMP_W'(byte_count_next);

  always_comb begin
    res.status       = status;
    res.done_res     = complete_f(received_map_next, extent_count_next, chunk_count_next,
                                  byte_count_next, exp_bytes_next, exp_chunks_next,
                                  totals_known_next, finished_next);
    res.chunks_seen  = chunk_count_next;
    res.bytes_seen   = bytes_wide[BYTES_W-1:0];
    res.chunk_extent = extent_count_next;
    res.missing_mask = MASK_W'(missing);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_map <= '0;
      extent_count <= '0;
      chunk_count  <= '0;
      byte_count   <= '0;
      exp_bytes    <= '0;
      exp_chunks   <= '0;
      totals_known <= 1'b0;
      finished     <= 1'b0;
    end else if (fire) begin
      received_map <= received_map_next;
      extent_count <= extent_count_next;
      chunk_count  <= chunk_count_next;
      byte_count   <= byte_count_next;
      exp_bytes    <= exp_bytes_next;
      exp_chunks   <= exp_chunks_next;
      totals_known <= totals_known_next;
      finished     <= finished_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/crs_out_reg.sv */
// Result register stage of the chunk reassembly scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module crs_out_reg
  import crs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         up_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res
);

  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/chunk_reassembly_scoreboard_unit.sv */
// Top level of the chunk reassembly scoreboard.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid / in_ready  | opcode seqno chunk_len total_bytes
//          |           |                      | total_chunks
//  out     | output    | out_valid/out_ready  | status done_res chunks_seen bytes_seen
//          |           |                      | chunk_extent missing_mask
//
// One transaction per cycle sustained while out_ready stays high; each transaction is registered
// in the input register, then its result in the result register, and a stall can come between.
// The bitmap update, counter update and missing-mask reduction are combinational between the
// input register and the result register.
// Synchronous reset clears the scoreboard state and both stage valid flags.
// A stalled result holds in the output register while one further transaction waits in the
// input register; in_ready drops only when both are full and out_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module chunk_reassembly_scoreboard_unit
  import crs_pkg::*;
#(
  parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF,
  parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [SEQ_W-1:0]    seqno,
  input  wire logic [LEN_W-1:0]    chunk_len,
  input  wire logic [TOTB_W-1:0]   total_bytes,
  input  wire logic [CNT_W-1:0]    total_chunks,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               status,
  output logic                     done_res,
  output logic [CNT_W-1:0]         chunks_seen,
  output logic [BYTES_W-1:0]       bytes_seen,
  output logic [CNT_W-1:0]         chunk_extent,
  output logic [MASK_W-1:0]        missing_mask
);

  item_t   item_in;
  item_t   item;
  result_t res_core;
  result_t res;
  logic    stage_valid;
  logic    stage_fire;
  logic    up_ready;

  assign item_in.opcode       = opcode;
  assign item_in.seqno        = seqno;
  assign item_in.chunk_len    = chunk_len;
  assign item_in.total_bytes  = total_bytes;
  assign item_in.total_chunks = total_chunks;

  crs_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item_in     (item_in),
    .down_ready  (up_ready),
    .stage_valid (stage_valid),
    .stage_fire  (stage_fire),
    .item        (item)
  );

  crs_core #(
    .MAX_CHUNKS      (MAX_CHUNKS),
    .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (stage_fire),
    .item (item),
    .res  (res_core)
  );

  crs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (stage_fire),
    .res_in    (res_core),
    .up_ready  (up_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign status       = res.status;
  assign done_res     = res.done_res;
  assign chunks_seen  = res.chunks_seen;
  assign bytes_seen   = res.bytes_seen;
  assign chunk_extent = res.chunk_extent;
  assign missing_mask = res.missing_mask;

  // A cleared result reports an empty scoreboard
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.status == ST_CLEARED) |->
      (chunks_seen == '0 && bytes_seen == '0 && chunk_extent == '0 &&
       missing_mask == '0 && !done_res))
    else $error("cleared result does not report an empty scoreboard");

  // A complete message has no gaps and its chunks fill the extent exactly
  a_done_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (missing_mask == '0 && chunks_seen == chunk_extent))
    else $error("completion reported with missing chunks");

  // Distinct chunks never outnumber the extent
  a_count_in_extent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chunks_seen <= chunk_extent))
    else $error("chunk count exceeds extent");

  // A transaction leaving the input stage lands in the result register
  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    stage_fire |=> out_valid)
    else $error("transaction lost between input and result stage");

endmodule

`default_nettype wire

/* dv/chunk_reassembly_scoreboard_unit_tb.sv */
// Self-checking testbench for the chunk reassembly scoreboard top level.
`timescale 1ns / 1ps

module chunk_reassembly_scoreboard_unit_tb;
  import crs_pkg::*;

  localparam int                CHUNK_CAP = MAX_CHUNKS_DEF;
  localparam int                BYTE_BITS = BYTE_COUNT_BITS_DEF;
  localparam logic [OP_W-1:0]   OP_SPARE  = 2'd3;
  localparam int                CALM_LEFT = 120;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     opcode = '0;
  logic [SEQ_W-1:0]    seqno = '0;
  logic [LEN_W-1:0]    chunk_len = '0;
  logic [TOTB_W-1:0]   total_bytes = '0;
  logic [CNT_W-1:0]    total_chunks = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          status;
  logic                done_res;
  logic [CNT_W-1:0]    chunks_seen;
  logic [BYTES_W-1:0]  bytes_seen;
  logic [CNT_W-1:0]    chunk_extent;
  logic [MASK_W-1:0]   missing_mask;

  chunk_reassembly_scoreboard_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .seqno        (seqno),
    .chunk_len    (chunk_len),
    .total_bytes  (total_bytes),
    .total_chunks (total_chunks),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .done_res     (done_res),
    .chunks_seen  (chunks_seen),
    .bytes_seen   (bytes_seen),
    .chunk_extent (chunk_extent),
    .missing_mask (missing_mask)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Tracker copy of the message state
  logic [MASK_W-1:0]    got_map = '0;
  logic [CNT_W-1:0]     ext_cnt = '0;
  logic [CNT_W-1:0]     chunk_cnt = '0;
  logic [BYTE_BITS-1:0] byte_cnt = '0;
  logic [TOTB_W-1:0]    tgt_bytes = '0;
  logic [CNT_W-1:0]     tgt_chunks = '0;
  logic                 tgt_known = 1'b0;
  logic                 fin_seen = 1'b0;

  item_t   pending_events[$];
  result_t predicted_reports[$];
  item_t   cur_event;
  item_t   send_event;
  result_t want;
  int      err_cnt = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  bit      in_taken = 1'b0;

  function automatic logic [MASK_W-1:0] below_mask(input int n);
    if (n >= MASK_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic bit whole_message();
    if (!tgt_known || !fin_seen) return 1'b0;
    if (byte_cnt != tgt_bytes) return 1'b0;
    if (chunk_cnt != tgt_chunks) return 1'b0;
    return (~got_map & below_mask(int'(ext_cnt))) == '0;
  endfunction

  function automatic result_t advance_tracker(input item_t ev);
    result_t            r;
    logic [BYTE_BITS:0] sum;
    int                 lim;
    r = '0;
    r.status = ST_ACCEPTED;
    case (ev.opcode)
      OP_CLEAR: begin
        got_map = '0;
        ext_cnt = '0;
        chunk_cnt = '0;
        byte_cnt = '0;
        tgt_bytes = '0;
        tgt_chunks = '0;
        tgt_known = 1'b0;
        fin_seen = 1'b0;
        r.status = ST_CLEARED;
      end
      OP_ADD: begin
        // expected-count check takes priority over capacity
        if (whole_message()) r.status = ST_ALREADY_COMPLETE;
        else if (tgt_known && {1'b0, ev.seqno} >= {2'b0, tgt_chunks})
          r.status = ST_BEYOND_EXPECTED;
        else if (int'(ev.seqno) >= CHUNK_CAP) r.status = ST_BEYOND_CAPACITY;
        else if (got_map[ev.seqno]) r.status = ST_DUPLICATE;
        else begin
          got_map[ev.seqno] = 1'b1;
          chunk_cnt = chunk_cnt + CNT_W'(1);
          sum = {1'b0, byte_cnt} + (BYTE_BITS + 1)'(ev.chunk_len);
          byte_cnt = sum[BYTE_BITS] ? {BYTE_BITS{1'b1}} : sum[BYTE_BITS-1:0];
          if (int'(ev.seqno) + 1 > int'(ext_cnt)) ext_cnt = CNT_W'(int'(ev.seqno) + 1);
        end
      end
      OP_FINISH: begin
        if (whole_message()) r.status = ST_ALREADY_COMPLETE;
        else begin
          fin_seen = 1'b1;
          if (tgt_known) r.status = ST_TOTALS_SET;
          else begin
            tgt_bytes = ev.total_bytes;
            tgt_chunks = ev.total_chunks;
            tgt_known = 1'b1;
            if (ext_cnt > ev.total_chunks) r.status = ST_EXTENT_EXCEEDS;
          end
        end
      end
      default: r.status = ST_ACCEPTED;
    endcase
    lim = int'(ext_cnt);
    if (tgt_known && int'(tgt_chunks) > lim) lim = int'(tgt_chunks);
    if (lim > CHUNK_CAP) lim = CHUNK_CAP;
    r.done_res = whole_message();
    r.chunks_seen = chunk_cnt;
    r.bytes_seen = byte_cnt[BYTES_W-1:0];
    r.chunk_extent = ext_cnt;
    r.missing_mask = ~got_map & below_mask(lim);
    return r;
  endfunction

  task automatic flag_field(input string fname, input logic [63:0] exp_v,
                            input logic [63:0] act_v);
    err_cnt++;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (predicted_reports.size() == 0) begin
          err_cnt++;
          $display("%0t ns: unexpected transaction, expected none, actual status %0d mask %0h",
                   $time, status, missing_mask);
        end else begin
          want = predicted_reports[0];
          predicted_reports.delete(0);
          if (status !== want.status)
            flag_field("status", 64'(want.status), 64'(status));
          if (done_res !== want.done_res)
            flag_field("done_res", 64'(want.done_res), 64'(done_res));
          if (chunks_seen !== want.chunks_seen)
            flag_field("chunks_seen", 64'(want.chunks_seen), 64'(chunks_seen));
          if (bytes_seen !== want.bytes_seen)
            flag_field("bytes_seen", 64'(want.bytes_seen), 64'(bytes_seen));
          if (chunk_extent !== want.chunk_extent)
            flag_field("chunk_extent", 64'(want.chunk_extent), 64'(chunk_extent));
          if (missing_mask !== want.missing_mask)
            flag_field("missing_mask", want.missing_mask, missing_mask);
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        cur_event.opcode = opcode;
        cur_event.seqno = seqno;
        cur_event.chunk_len = chunk_len;
        cur_event.total_bytes = total_bytes;
        cur_event.total_chunks = total_chunks;
        predicted_reports = {predicted_reports, advance_tracker(cur_event)};
      end
    end
  end

  // Drive the input channel at the falling edge
  always @(negedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        send_event = pending_events[0];
        pending_events.delete(0);
        opcode <= send_event.opcode;
        seqno <= send_event.seqno;
        chunk_len <= send_event.chunk_len;
        total_bytes <= send_event.total_bytes;
        total_chunks <= send_event.total_chunks;
        in_valid <= 1'b1;
        if (pending_events.size() > CALM_LEFT && $urandom_range(0, 7) == 0)
          in_gap = $urandom_range(1, 6);
      end else in_valid <= 1'b0;
    end
  end

  // Drive back-pressure at the falling edge
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (pending_events.size() > CALM_LEFT && $urandom_range(0, 9) == 0)
        out_gap = $urandom_range(1, 6);
    end
  end

  task automatic queue_event(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                             input logic [LEN_W-1:0] len, input logic [TOTB_W-1:0] tb,
                             input logic [CNT_W-1:0] tc);
    item_t ev;
    ev.opcode = op;
    ev.seqno = seq;
    ev.chunk_len = len;
    ev.total_bytes = tb;
    ev.total_chunks = tc;
    pending_events = {pending_events, ev};
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return LEN_W'($urandom_range(0, 65535));
  endfunction

  // Well-formed message with random order, lengths and occasional breakage
  task automatic gen_message();
    int                n, i, j, t, skip;
    int                order[64];
    logic [LEN_W-1:0]  lens[64];
    logic [TOTB_W-1:0] sum;
    logic [CNT_W-1:0]  tc;
    bit                fin_first, drop;
    if ($urandom_range(0, 9) != 0) queue_event(OP_CLEAR, '0, '0, '0, '0);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    sum = '0;
    for (i = 0; i < n; i++) begin
      order[i] = i;
      lens[i] = pick_len();
      sum += TOTB_W'(lens[i]);
    end
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    drop = ($urandom_range(0, 9) == 0);
    skip = $urandom_range(0, n - 1);
    if ($urandom_range(0, 11) == 0) sum = sum + $urandom_range(1, 1000);
    tc = CNT_W'(n);
    t = $urandom_range(0, 15);
    if (t == 0) tc = CNT_W'(n + $urandom_range(1, 3));
    else if (t == 1) tc = CNT_W'(n - 1);
    fin_first = ($urandom_range(0, 2) == 0);
    if (fin_first)
      queue_event(OP_FINISH, SEQ_W'($urandom), LEN_W'($urandom), sum, tc);
    for (i = 0; i < n; i++) begin
      if (!(drop && i == skip))
        queue_event(OP_ADD, SEQ_W'(order[i]), lens[order[i]], $urandom,
                    CNT_W'($urandom));
      if ($urandom_range(0, 9) == 0)
        queue_event(OP_ADD, SEQ_W'(order[$urandom_range(0, i)]), pick_len(), $urandom,
                    CNT_W'($urandom));
      if ($urandom_range(0, 19) == 0)
        queue_event(OP_ADD, SEQ_W'($urandom_range(n, 255)), pick_len(), $urandom,
                    CNT_W'($urandom));
    end
    if (!fin_first)
      queue_event(OP_FINISH, SEQ_W'($urandom), LEN_W'($urandom), sum, tc);
    if ($urandom_range(0, 3) == 0)
      queue_event(OP_ADD, SEQ_W'($urandom_range(0, 255)), pick_len(), $urandom,
                  CNT_W'($urandom));
    if ($urandom_range(0, 3) == 0)
      queue_event(OP_FINISH, SEQ_W'($urandom), LEN_W'($urandom), $urandom,
                  CNT_W'($urandom_range(0, 64)));
  endtask

  task automatic gen_noise();
    int k, r;
    logic [OP_W-1:0] op;
    k = $urandom_range(1, 4);
    repeat (k) begin
      r = $urandom_range(0, 15);
      op = (r == 15) ? OP_SPARE : OP_W'(r % 3);
      queue_event(op, ($urandom_range(0, 1) != 0) ? SEQ_W'($urandom_range(0, 255))
                                                  : SEQ_W'($urandom_range(0, 7)),
                  LEN_W'($urandom), $urandom, CNT_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    // Directed: capacity edges, rejections and completion paths
    queue_event(OP_CLEAR, '0, '0, '0, '0);
    queue_event(OP_ADD, 8'd0, 16'hFFFF, '0, '0);
    queue_event(OP_ADD, 8'd0, 16'h1234, '0, '0);
    queue_event(OP_ADD, 8'd63, 16'h0000, '0, '0);
    queue_event(OP_ADD, 8'd64, 16'h0001, '0, '0);
    queue_event(OP_ADD, 8'd255, 16'hFFFF, '1, '1);
    queue_event(OP_SPARE, '1, '1, '1, '1);
    queue_event(OP_FINISH, '0, '0, 32'hFFFF_FFFF, 7'd1);
    queue_event(OP_FINISH, '0, '0, 32'd5, 7'd5);
    queue_event(OP_ADD, 8'd1, 16'd7, '0, '0);
    queue_event(OP_CLEAR, '1, '1, '1, '1);
    queue_event(OP_FINISH, '0, '0, 32'd65535, 7'd127);
    queue_event(OP_ADD, 8'd0, 16'hFFFF, '0, '0);
    queue_event(OP_ADD, 8'd100, 16'd3, '0, '0);
    queue_event(OP_CLEAR, '0, '0, '0, '0);
    queue_event(OP_ADD, 8'd1, 16'd10, '0, '0);
    queue_event(OP_ADD, 8'd0, 16'd20, '0, '0);
    queue_event(OP_FINISH, '0, '0, 32'd30, 7'd2);
    queue_event(OP_ADD, 8'd0, 16'd1, '0, '0);
    queue_event(OP_FINISH, '0, '0, 32'd30, 7'd2);
    queue_event(OP_SPARE, '0, '0, '0, '0);
    queue_event(OP_CLEAR, '0, '0, '0, '0);
    queue_event(OP_FINISH, '0, '0, 32'd0, 7'd64);
    queue_event(OP_CLEAR, '0, '0, '0, '0);
    queue_event(OP_FINISH, '0, '0, 32'd0, 7'd0);
    while (pending_events.size() < 1540) begin
      if ($urandom_range(0, 3) != 0) gen_message();
      else gen_noise();
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || in_valid) @(posedge clk);
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
